// ----- src/json_number_scanner_core_macros.svh -----
// Assertion macros for the JSON number scanner.
`ifndef JSON_NUMBER_SCANNER_CORE_MACROS_SVH
`define JSON_NUMBER_SCANNER_CORE_MACROS_SVH
`ifndef SYNTH
`define JNS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("json number scanner: assertion failed");
`define JNS_ASSERT_IMPL(label, cond, concl) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (concl)) \
    else $error("json number scanner: implication failed");
`else
`define JNS_ASSERT(label, prop)
`define JNS_ASSERT_IMPL(label, cond, concl)
`endif
`endif

// ----- src/jns_pkg.sv -----
// Types, codes and character constants for the JSON number scanner.
package jns_pkg;

  localparam logic [15:0] CH_NUL   = 16'd0;
  localparam logic [15:0] CH_TAB   = 16'd9;
  localparam logic [15:0] CH_LF    = 16'd10;
  localparam logic [15:0] CH_CR    = 16'd13;
  localparam logic [15:0] CH_SPACE = 16'd32;
  localparam logic [15:0] CH_PLUS  = 16'd43;
  localparam logic [15:0] CH_MINUS = 16'd45;
  localparam logic [15:0] CH_POINT = 16'd46;
  localparam logic [15:0] CH_ZERO  = 16'd48;
  localparam logic [15:0] CH_NINE  = 16'd57;
  localparam logic [15:0] CH_UPPER_E = 16'd69;
  localparam logic [15:0] CH_LOWER_E = 16'd101;

  localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
  localparam logic [16:0] EXP_MAG_MAX = 17'h1FFFF;

  localparam logic [1:0] STATUS_INT   = 2'd0;
  localparam logic [1:0] STATUS_FLOAT = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  typedef enum logic [3:0] {
    PH_START    = 4'd0,
    PH_MINUS    = 4'd1,
    PH_ZERO     = 4'd2,
    PH_INT      = 4'd3,
    PH_POINT    = 4'd4,
    PH_FRAC     = 4'd5,
    PH_EXP_E    = 4'd6,
    PH_EXP_SIGN = 4'd7,
    PH_EXP_DIG  = 4'd8
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic        sign_seen;
    logic [63:0] acc;
    logic        acc_sat;
    logic [15:0] frac_count;
    logic        exp_neg;
    logic [16:0] exp_acc;
    logic [15:0] char_count;
    logic        float_seen;
  } scan_state_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               negative;
    logic [63:0]        significand;
    logic               significand_overflow;
    logic signed [16:0] decimal_exponent;
    logic [15:0]        length;
    logic [15:0]        end_char;
  } scan_result_t;

  localparam scan_state_t STATE_CLEAR = '{
    phase: PH_START, sign_seen: 1'b0, acc: 64'd0, acc_sat: 1'b0,
    frac_count: 16'd0, exp_neg: 1'b0, exp_acc: 17'd0, char_count: 16'd0,
    float_seen: 1'b0
  };

endpackage

// ----- src/jns_step.sv -----
// Per-character step of the number scanner: next state and result.
module jns_step (
  input  jns_pkg::scan_state_t  st,
  input  logic [15:0]           ch,
  input  logic                  top_level,
  output jns_pkg::scan_state_t  nxt,
  output logic                  emit,
  output jns_pkg::scan_result_t res
);

  logic        dig;
  logic [3:0]  d;
  logic        ws;
  logic        is_e;
  logic        lead;
  logic        exp_lead;
  logic        err;
  logic [67:0] acc10;
  logic [63:0] acc_add;
  logic        sat_add;
  logic [20:0] exp10;
  logic [16:0] exp_add;
  logic [15:0] cnt_inc;
  logic [15:0] frac_inc;
  logic signed [18:0] exp_signed;
  logic signed [18:0] exp_net;

  assign dig  = (ch >= jns_pkg::CH_ZERO) && (ch <= jns_pkg::CH_NINE);
  assign d    = dig ? ch[3:0] : 4'd0;
  assign ws   = ch inside {jns_pkg::CH_SPACE, jns_pkg::CH_TAB, jns_pkg::CH_LF, jns_pkg::CH_CR};
  assign is_e = ch inside {jns_pkg::CH_LOWER_E, jns_pkg::CH_UPPER_E};

  // acc * 10 + d as two shifts and two adds; any carry past bit 63 saturates
  assign acc10 = ({4'd0, st.acc} << 3) + ({4'd0, st.acc} << 1) + {64'd0, d};
  always_comb begin
    if (st.acc_sat) begin
      acc_add = st.acc;
      sat_add = 1'b1;
    end else if (acc10[67:64] != 4'd0) begin
      acc_add = '1;
      sat_add = 1'b1;
    end else begin
      acc_add = acc10[63:0];
      sat_add = 1'b0;
    end
  end

  assign exp10   = ({4'd0, st.exp_acc} << 3) + ({4'd0, st.exp_acc} << 1) + {17'd0, d};
  assign exp_add = (exp10 > {4'd0, jns_pkg::EXP_MAG_MAX}) ? jns_pkg::EXP_MAG_MAX : exp10[16:0];

  assign cnt_inc  = (st.char_count < jns_pkg::COUNT_MAX) ? st.char_count + 16'd1 : st.char_count;
  assign frac_inc = (st.frac_count < jns_pkg::COUNT_MAX) ? st.frac_count + 16'd1 : st.frac_count;

  // minus phase and a start character that is neither skipped nor a minus share one path
  assign lead = (st.phase == jns_pkg::PH_MINUS) ||
                ((st.phase == jns_pkg::PH_START) && !(top_level && ws) &&
                 (ch != jns_pkg::CH_MINUS));
  assign exp_lead = (st.phase == jns_pkg::PH_EXP_SIGN) ||
                    ((st.phase == jns_pkg::PH_EXP_E) &&
                     !(ch inside {jns_pkg::CH_PLUS, jns_pkg::CH_MINUS}));

  // decode: does this character end the number, and is that an error
  always_comb begin
    emit = 1'b0;
    err  = 1'b0;
    if (lead) begin
      emit = !dig;
      err  = !dig;
    end else if (exp_lead) begin
      emit = !dig;
      err  = !dig;
    end else begin
      case (st.phase)
        jns_pkg::PH_ZERO:    emit = (ch != jns_pkg::CH_POINT);
        jns_pkg::PH_INT:     emit = !dig && (ch != jns_pkg::CH_POINT) && !is_e;
        jns_pkg::PH_POINT: begin
          emit = !dig;
          err  = !dig;
        end
        jns_pkg::PH_FRAC:    emit = !dig && !is_e;
        jns_pkg::PH_EXP_DIG: emit = !dig;
        default: begin
          emit = 1'b0;
          err  = 1'b0;
        end
      endcase
    end
  end

  // next state
  always_comb begin
    nxt = st;
    if (emit) begin
      nxt = jns_pkg::STATE_CLEAR;
    end else if (lead) begin
      nxt.char_count = cnt_inc;
      if (ch == jns_pkg::CH_ZERO) begin
        nxt.phase = jns_pkg::PH_ZERO;
      end else begin
        nxt.acc     = acc_add;
        nxt.acc_sat = sat_add;
        nxt.phase   = jns_pkg::PH_INT;
      end
    end else if (exp_lead) begin
      nxt.exp_acc    = exp_add;
      nxt.char_count = cnt_inc;
      nxt.phase      = jns_pkg::PH_EXP_DIG;
    end else begin
      case (st.phase)
        jns_pkg::PH_START: begin
          if (!(top_level && ws)) begin
            nxt.sign_seen  = 1'b1;
            nxt.char_count = cnt_inc;
            nxt.phase      = jns_pkg::PH_MINUS;
          end
        end
        jns_pkg::PH_ZERO: begin
          nxt.char_count = cnt_inc;
          nxt.phase      = jns_pkg::PH_POINT;
        end
        jns_pkg::PH_INT: begin
          nxt.char_count = cnt_inc;
          if (dig) begin
            nxt.acc     = acc_add;
            nxt.acc_sat = sat_add;
          end else if (ch == jns_pkg::CH_POINT) begin
            nxt.phase = jns_pkg::PH_POINT;
          end else begin
            nxt.phase = jns_pkg::PH_EXP_E;
          end
        end
        jns_pkg::PH_POINT, jns_pkg::PH_FRAC: begin
          nxt.char_count = cnt_inc;
          if (dig) begin
            nxt.acc        = acc_add;
            nxt.acc_sat    = sat_add;
            nxt.frac_count = frac_inc;
            nxt.float_seen = 1'b1;
            nxt.phase      = jns_pkg::PH_FRAC;
          end else begin
            nxt.phase = jns_pkg::PH_EXP_E;
          end
        end
        jns_pkg::PH_EXP_E: begin
          nxt.exp_neg    = (ch == jns_pkg::CH_MINUS);
          nxt.char_count = cnt_inc;
          nxt.phase      = jns_pkg::PH_EXP_SIGN;
        end
        jns_pkg::PH_EXP_DIG: begin
          nxt.exp_acc    = exp_add;
          nxt.char_count = cnt_inc;
        end
        default: nxt = jns_pkg::STATE_CLEAR;
      endcase
    end
  end

  // result fields
  assign exp_signed = st.exp_neg ? -$signed({2'b00, st.exp_acc}) : $signed({2'b00, st.exp_acc});
  assign exp_net    = exp_signed - $signed({3'b000, st.frac_count});

  always_comb begin
    res.status               = err ? jns_pkg::STATUS_ERROR :
                               (st.float_seen ? jns_pkg::STATUS_FLOAT : jns_pkg::STATUS_INT);
    res.negative             = st.sign_seen;
    res.significand          = err ? 64'd0 : st.acc;
    res.significand_overflow = err ? 1'b0 : st.acc_sat;
    res.length               = st.char_count;
    res.end_char             = ch;
    if (err) begin
      res.decimal_exponent = 17'sd0;
    end else if (exp_net < -19'sd65536) begin
      res.decimal_exponent = -17'sd65536;
    end else if (exp_net > 19'sd65535) begin
      res.decimal_exponent = 17'sd65535;
    end else begin
      res.decimal_exponent = exp_net[16:0];
    end
  end

endmodule

// ----- src/json_number_scanner_core.sv -----
// Top level of the JSON number scanner: input register, scan state, result register.
// Takes one 16-bit character per transfer and emits one result when a character ends a
// number or breaks its syntax; that ending character is consumed and reported as end_char.
// A character can be taken every cycle unless input stalls: it is held in the input register
// and then folded into the scan state by combinational logic (the 64-bit times-ten accumulate
// sets the clock), and a result passes through the input register and then the result register.
// While a result waits, characters that do not end a number keep flowing; one that does
// is held in the input register, and input stalls, until the pending result is taken.
// Write top_level (reset 1, skip leading whitespace) only while no number is in progress.
`include "json_number_scanner_core_macros.svh"
module json_number_scanner_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        ch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               negative,
  output logic [63:0]        significand,
  output logic               significand_overflow,
  output logic signed [16:0] decimal_exponent,
  output logic [15:0]        length,
  output logic [15:0]        end_char
);

  logic                  top_level;
  logic                  in_full;
  logic [15:0]           in_ch;
  logic                  fire;
  logic                  emit;
  jns_pkg::scan_state_t  st;
  jns_pkg::scan_state_t  st_next;
  jns_pkg::scan_result_t res;

  // only a character that ends a number has to wait for the result register
  assign fire     = in_full && (!emit || !out_valid || out_ready);
  assign in_ready = !in_full || fire;

  jns_step u_step (
    .st        (st),
    .ch        (in_ch),
    .top_level (top_level),
    .nxt       (st_next),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      top_level <= 1'b1;
    end else if (cfg_wr_en) begin
      top_level <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_ch <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= jns_pkg::STATE_CLEAR;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      status               <= res.status;
      negative             <= res.negative;
      significand          <= res.significand;
      significand_overflow <= res.significand_overflow;
      decimal_exponent     <= res.decimal_exponent;
      length               <= res.length;
      end_char             <= res.end_char;
    end
  end

  // an error result carries no number
  `JNS_ASSERT_IMPL(a_error_clean, out_valid && (status == jns_pkg::STATUS_ERROR), (significand == 64'd0) && !significand_overflow && (decimal_exponent == 17'sd0))
  // saturation pins the significand at all ones
  `JNS_ASSERT_IMPL(a_sat_all_ones, out_valid && significand_overflow, significand == '1)
  // nothing is counted or accumulated before the first character of a number
  `JNS_ASSERT_IMPL(a_start_clear, st.phase == jns_pkg::PH_START, (st.char_count == 16'd0) && (st.acc == 64'd0) && !st.sign_seen)
  // a new result is only loaded into a free or draining output register
  `JNS_ASSERT(a_no_overwrite, (out_valid && !out_ready) |=> $stable(end_char) && out_valid)

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the JSON number scanner core.
module tb_top;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          ITEM_TARGET  = 1250;
  localparam logic [15:0] CH_COMMA     = 16'd44;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic               cfg_wr_data;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        ch;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic               negative;
  logic [63:0]        significand;
  logic               significand_overflow;
  logic signed [16:0] decimal_exponent;
  logic [15:0]        length;
  logic [15:0]        end_char;

  // scanner state as predicted
  logic             skip_ws;
  jns_pkg::phase_t  num_phase;
  logic             num_negative;
  logic [63:0]      digits;
  logic             digits_sat;
  logic [15:0]      frac_digits;
  logic             exp_minus;
  logic [16:0]      exp_mag;
  logic [15:0]      num_len;
  logic             saw_fraction;

  jns_pkg::scan_result_t expected_numbers[$];
  jns_pkg::scan_result_t want;

  int tx_max_gap = 0;
  int rx_max_gap = 0;
  int mismatches = 0;
  int results_checked = 0;
  int chars_taken = 0;
  int cycle_count = 0;
  int cfg_writes = 0;
  int n_int = 0;
  int n_float = 0;
  int n_error = 0;
  int n_saturated = 0;

  json_number_scanner_core uut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .ch                   (ch),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .status               (status),
    .negative             (negative),
    .significand          (significand),
    .significand_overflow (significand_overflow),
    .decimal_exponent     (decimal_exponent),
    .length               (length),
    .end_char             (end_char)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 expected_numbers.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_number();
    num_phase    = jns_pkg::PH_START;
    num_negative = 1'b0;
    digits       = 64'd0;
    digits_sat   = 1'b0;
    frac_digits  = 16'd0;
    exp_minus    = 1'b0;
    exp_mag      = 17'd0;
    num_len      = 16'd0;
    saw_fraction = 1'b0;
  endfunction

  function automatic void bump_len();
    if (num_len != jns_pkg::COUNT_MAX) num_len++;
  endfunction

  function automatic void push_digit(input logic [3:0] d);
    if (!digits_sat) begin
      if (digits > (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10) begin
        digits     = 64'hFFFF_FFFF_FFFF_FFFF;
        digits_sat = 1'b1;
      end else begin
        digits = digits * 64'd10 + 64'(d);
      end
    end
  endfunction

  function automatic void push_exp_digit(input logic [3:0] d);
    int v;
    v = int'(exp_mag) * 10 + int'(d);
    exp_mag = (v > int'(jns_pkg::EXP_MAG_MAX)) ? jns_pkg::EXP_MAG_MAX : 17'(v);
  endfunction

  function automatic void close_number(input logic [15:0] c, input logic bad);
    jns_pkg::scan_result_t r;
    int e;
    e = exp_minus ? -int'(exp_mag) : int'(exp_mag);
    e = e - int'(frac_digits);
    if (e < -65536) e = -65536;
    if (e > 65535) e = 65535;
    r.status               = bad ? jns_pkg::STATUS_ERROR :
                             (saw_fraction ? jns_pkg::STATUS_FLOAT : jns_pkg::STATUS_INT);
    r.negative             = num_negative;
    r.significand          = bad ? 64'd0 : digits;
    r.significand_overflow = bad ? 1'b0 : digits_sat;
    r.decimal_exponent     = bad ? 17'sd0 : e[16:0];
    r.length               = num_len;
    r.end_char             = c;
    expected_numbers.push_back(r);
    if (bad) n_error++;
    else if (saw_fraction) n_float++;
    else n_int++;
    if (!bad && digits_sat) n_saturated++;
    clear_number();
  endfunction

  // advance the predicted scan by one transferred character
  function automatic void scan_char(input logic [15:0] c);
    logic       is_dig;
    logic       is_ws;
    logic       is_e;
    logic [3:0] d;
    is_dig = (c >= jns_pkg::CH_ZERO) && (c <= jns_pkg::CH_NINE);
    is_ws  = (c == jns_pkg::CH_SPACE) || (c == jns_pkg::CH_TAB) ||
             (c == jns_pkg::CH_LF) || (c == jns_pkg::CH_CR);
    is_e   = (c == jns_pkg::CH_LOWER_E) || (c == jns_pkg::CH_UPPER_E);
    d      = is_dig ? 4'(c - jns_pkg::CH_ZERO) : 4'd0;
    chars_taken++;
    case (num_phase)
      jns_pkg::PH_START, jns_pkg::PH_MINUS: begin
        if (num_phase == jns_pkg::PH_START && skip_ws && is_ws) begin
          // leading whitespace dropped
        end else if (num_phase == jns_pkg::PH_START && c == jns_pkg::CH_MINUS) begin
          num_negative = 1'b1;
          bump_len();
          num_phase = jns_pkg::PH_MINUS;
        end else if (c == jns_pkg::CH_ZERO) begin
          bump_len();
          num_phase = jns_pkg::PH_ZERO;
        end else if (is_dig) begin
          push_digit(d);
          bump_len();
          num_phase = jns_pkg::PH_INT;
        end else begin
          close_number(c, 1'b1);
        end
      end
      jns_pkg::PH_ZERO: begin
        if (c == jns_pkg::CH_POINT) begin
          bump_len();
          num_phase = jns_pkg::PH_POINT;
        end else begin
          close_number(c, 1'b0);
        end
      end
      jns_pkg::PH_INT: begin
        if (is_dig) begin
          push_digit(d);
          bump_len();
        end else if (c == jns_pkg::CH_POINT) begin
          bump_len();
          num_phase = jns_pkg::PH_POINT;
        end else if (is_e) begin
          bump_len();
          num_phase = jns_pkg::PH_EXP_E;
        end else begin
          close_number(c, 1'b0);
        end
      end
      jns_pkg::PH_POINT, jns_pkg::PH_FRAC: begin
        if (is_dig) begin
          push_digit(d);
          if (frac_digits != jns_pkg::COUNT_MAX) frac_digits++;
          bump_len();
          saw_fraction = 1'b1;
          num_phase = jns_pkg::PH_FRAC;
        end else if (num_phase == jns_pkg::PH_POINT) begin
          close_number(c, 1'b1);
        end else if (is_e) begin
          bump_len();
          num_phase = jns_pkg::PH_EXP_E;
        end else begin
          close_number(c, 1'b0);
        end
      end
      jns_pkg::PH_EXP_E, jns_pkg::PH_EXP_SIGN: begin
        if (num_phase == jns_pkg::PH_EXP_E &&
            (c == jns_pkg::CH_PLUS || c == jns_pkg::CH_MINUS)) begin
          exp_minus = (c == jns_pkg::CH_MINUS);
          bump_len();
          num_phase = jns_pkg::PH_EXP_SIGN;
        end else if (is_dig) begin
          push_exp_digit(d);
          bump_len();
          num_phase = jns_pkg::PH_EXP_DIG;
        end else begin
          close_number(c, 1'b1);
        end
      end
      jns_pkg::PH_EXP_DIG: begin
        if (is_dig) begin
          push_exp_digit(d);
          bump_len();
        end else begin
          close_number(c, 1'b0);
        end
      end
      default: clear_number();
    endcase
  endfunction

  // ------------------------------------------------------------------ checking

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp_v);
    if (got !== exp_v)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h", results_checked, name,
                                got, exp_v));
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_checked));
      end else begin
        want = expected_numbers.pop_front();
        check_field("status", 64'(status), 64'(want.status));
        check_field("negative", 64'(negative), 64'(want.negative));
        check_field("significand", significand, want.significand);
        check_field("significand_overflow", 64'(significand_overflow),
                    64'(want.significand_overflow));
        check_field("decimal_exponent", {47'd0, decimal_exponent},
                    {47'd0, want.decimal_exponent});
        check_field("length", 64'(length), 64'(want.length));
        check_field("end_char", 64'(end_char), 64'(want.end_char));
      end
    end
  end

  // result side: fresh stall drawn for every result transfer
  initial begin
    int gap;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, rx_max_gap);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // ------------------------------------------------------------------ stimulus

  // Starts and ends at a falling edge; valid is left high for the caller's next
  // send or drain, so it is never lowered and raised in the same step.
  task automatic send_char(input logic [15:0] c);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    do @(posedge clk); while (!in_ready);
    scan_char(c);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char({8'd0, s[i]});
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_char(jns_pkg::CH_ZERO + 16'($urandom_range(0, 9)));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_numbers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_top_level(input logic v);
    if (num_phase != jns_pkg::PH_START) send_char(CH_COMMA);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    skip_ws = v;
    cfg_writes++;
  endtask

  function automatic logic [15:0] pick_space();
    case ($urandom_range(0, 3))
      0: return jns_pkg::CH_SPACE;
      1: return jns_pkg::CH_TAB;
      2: return jns_pkg::CH_LF;
      default: return jns_pkg::CH_CR;
    endcase
  endfunction

  function automatic int pick_gap_limit();
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return 3;
      default: return 16;
    endcase
  endfunction

  // ------------------------------------------------------------------- tests

  task automatic test_whitespace_and_sign();
    tx_max_gap = 16;
    rx_max_gap = 16;
    send_char(jns_pkg::CH_SPACE);
    send_char(jns_pkg::CH_TAB);
    send_char(jns_pkg::CH_LF);
    send_char(jns_pkg::CH_CR);
    send_text("-0,-7}");
  endtask

  task automatic test_integer_forms();
    tx_max_gap = 0;
    rx_max_gap = 16;
    // lone zero is ended by 'e' or a digit; a comma at the start is an error
    send_text("0e5,01,123E+45]");
  endtask

  task automatic test_fraction_and_exponent();
    tx_max_gap = 3;
    rx_max_gap = 0;
    send_text("0.5e-3,-12.250E+2 ");
  endtask

  task automatic test_syntax_errors();
    tx_max_gap = 16;
    rx_max_gap = 3;
    send_text("-.1.e1e+,1Ex+x");
  endtask

  task automatic test_saturation();
    tx_max_gap = 0;
    rx_max_gap = 16;
    send_text("18446744073709551615,18446744073709551616,1e999999,1.5e-999999,");
  endtask

  task automatic test_wide_chars();
    tx_max_gap = 3;
    rx_max_gap = 3;
    send_char(jns_pkg::CH_NUL);
    send_char(16'hFFFF);
    send_text("7");
    send_char(jns_pkg::CH_ZERO + 16'h0100);
    send_text("12");
    send_char(jns_pkg::CH_NUL);
  endtask

  task automatic test_strict_top_level();
    write_top_level(1'b0);
    send_char(jns_pkg::CH_SPACE);
    send_text("-4");
    send_char(jns_pkg::CH_TAB);
    write_top_level(1'b1);
  endtask

  // a long fraction saturates the significand while the fraction count keeps growing
  task automatic test_long_run();
    tx_max_gap = 0;
    rx_max_gap = 0;
    send_text("1.");
    send_digits(30);
    send_text("e+1,");
    wait_for_results();
  endtask

  task automatic send_random_number();
    if (skip_ws) repeat ($urandom_range(0, 2)) send_char(pick_space());
    if ($urandom_range(0, 1) == 1) send_char(jns_pkg::CH_MINUS);
    if ($urandom_range(0, 3) == 0) begin
      send_char(jns_pkg::CH_ZERO);
    end else begin
      send_char(jns_pkg::CH_ZERO + 16'($urandom_range(1, 9)));
      send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 7));
    end
    if ($urandom_range(0, 9) < 4) begin
      send_char(jns_pkg::CH_POINT);
      send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6));
    end
    if ($urandom_range(0, 9) < 3) begin
      send_char(($urandom_range(0, 1) == 1) ? jns_pkg::CH_LOWER_E : jns_pkg::CH_UPPER_E);
      case ($urandom_range(0, 2))
        0: send_char(jns_pkg::CH_PLUS);
        1: send_char(jns_pkg::CH_MINUS);
        default: ;
      endcase
      send_digits(($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3));
    end
    case ($urandom_range(0, 5))
      0: send_char(CH_COMMA);
      1: send_char(16'd93);
      2: send_char(16'd125);
      3: send_char(pick_space());
      4: send_char(jns_pkg::CH_NUL);
      default: send_char(16'($urandom));
    endcase
  endtask

  task automatic test_random_stream();
    string pool;
    int next_cfg;
    pool     = "0123456789.eE+- x";
    next_cfg = chars_taken + 300;
    while (chars_taken < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        tx_max_gap = pick_gap_limit();
        rx_max_gap = pick_gap_limit();
      end
      if (chars_taken >= next_cfg) begin
        write_top_level(!skip_ws);
        next_cfg += 300;
      end
      if ($urandom_range(0, 4) == 0) begin
        // broken fragments and arbitrary wide characters
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1) == 1) send_char(16'($urandom));
          else send_char({8'd0, pool[$urandom_range(0, pool.len() - 1)]});
        end
      end else begin
        send_random_number();
      end
      if (num_phase != jns_pkg::PH_START) send_char(CH_COMMA);
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    ch          = 16'd0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    skip_ws     = 1'b1;
    clear_number();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_whitespace_and_sign();
    test_integer_forms();
    test_fraction_and_exponent();
    test_syntax_errors();
    test_saturation();
    test_wide_chars();
    test_strict_top_level();
    test_long_run();
    test_random_stream();
    wait_for_results();

    $display("Checked %0d results from %0d characters: %0d integer, %0d floating, %0d errors",
             results_checked, chars_taken, n_int, n_float, n_error);
    $display("%0d saturated significands, %0d top_level writes, %0d mismatches",
             n_saturated, cfg_writes, mismatches);
    if (mismatches == 0 && expected_numbers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- json_number_scanner_core.f -----
+incdir+src
src/jns_pkg.sv
src/jns_step.sv
src/json_number_scanner_core.sv
test/tb_top.sv
